### sv/hhhc_pkg.sv
package hhhc_pkg;

  localparam int HumW     = 10;
  localparam int PctW     = 7;
  localparam int QualW    = 16;
  localparam int DwellCfgW = 20;
  localparam int CfgDataW = 20;
  localparam int CfgIdxW  = 2;
  localparam int ThW      = 12;   // signed threshold in tenths, covers -10 .. 1280
  localparam int QTimerW  = 17;
  localparam int DwellW   = 21;

  localparam logic [PctW-1:0]      SetpointRst = 7'd50;
  localparam logic [QualW-1:0]     QualifyRst  = 16'd10000;
  localparam logic [DwellCfgW-1:0] MinOnRst    = 20'd60000;
  localparam logic [DwellCfgW-1:0] MinOffRst   = 20'd300000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETPOINT = 2'd0,
    CFG_QUALIFY  = 2'd1,
    CFG_MIN_ON   = 2'd2,
    CFG_MIN_OFF  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_OFF  = 2'd0,
    ACT_ON   = 2'd1,
    ACT_NONE = 2'd3
  } act_t;

  typedef struct packed {
    logic [HumW-1:0] humidity_tenths;
    logic            heater_enabled;
  } in_item_t;

  typedef struct packed {
    logic heater_drive;
    logic below_flag;
    logic above_flag;
  } out_item_t;

  // qualifier decision for one threshold flag
  typedef struct packed {
    logic latched;
    logic restart;
  } qual_t;

endpackage

### sv/hhhc_qual.sv
module hhhc_qual (
  input  logic                         en,
  input  logic                         past,      // level strictly past the threshold
  input  logic                         back,      // level strictly on the other side
  input  logic                         latched,
  input  logic [hhhc_pkg::QTimerW-1:0] timer_inc,
  input  logic [hhhc_pkg::QualW-1:0]   qualify,
  output hhhc_pkg::qual_t              qual
);

  always_comb begin
    qual.latched = latched;
    qual.restart = 1'b0;
    if (en) begin
      if (back) begin
        // clear at once and restart the qualify time
        qual.latched = 1'b0;
        qual.restart = 1'b1;
      end else if (past && (timer_inc > {1'b0, qualify})) begin
        qual.latched = 1'b1;
      end
    end
  end

endmodule

### sv/humidity_heater_hysteresis_control.sv
// Channel  Direction  Handshake           Beat contents
// in_      input      in_valid/in_stall   humidity_tenths, heater_enabled
// out_     output     out_valid/out_stall heater_drive, below_flag, above_flag
// cfg_     input      cfg_valid/cfg_ready register index, write data (always ready)
//
// One beat per cycle while in_stall is low; results land in the output or skid register.
// All decision logic sits between the input port and a two-entry result buffer
// (output register plus skid entry), so a stalled result never blocks the next beat.
// in_stall rises only when the skid entry is full, and it comes straight from a register.
// rst_n (synchronous, active low) loads the register defaults, clears the timers and
// flags, turns the heater off and arms the immediate first change.
module humidity_heater_hysteresis_control (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hhhc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hhhc_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hhhc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hhhc_pkg::CfgDataW-1:0] cfg_data
);

  // configuration registers
  logic [hhhc_pkg::PctW-1:0]      setpoint_r;
  logic [hhhc_pkg::QualW-1:0]     qualify_r;
  logic [hhhc_pkg::DwellCfgW-1:0] min_on_r;
  logic [hhhc_pkg::DwellCfgW-1:0] min_off_r;

  // control state
  logic [hhhc_pkg::QTimerW-1:0] below_timer_r, below_timer_nxt;
  logic [hhhc_pkg::QTimerW-1:0] above_timer_r, above_timer_nxt;
  logic [hhhc_pkg::DwellW-1:0]  dwell_timer_r, dwell_timer_nxt;
  logic                         below_r, below_nxt;
  logic                         above_r, above_nxt;
  hhhc_pkg::act_t               last_act_r, last_act_nxt;
  logic                         first_r, first_nxt;
  logic                         heater_r, heater_nxt;

  // result buffer
  logic                 out_valid_r;
  hhhc_pkg::out_item_t  out_data_r;
  logic                 skid_valid_r;
  hhhc_pkg::out_item_t  skid_data_r;
  hhhc_pkg::out_item_t  result;

  logic acc;
  logic take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign acc       = in_valid && !skid_valid_r;
  assign take      = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Thresholds in tenths: (setpoint -/+ 1) * 10, signed so a zero setpoint
  // gives a low threshold below any reading.
  // ---------------------------------------------------------------------------
  logic signed [hhhc_pkg::ThW-1:0] low_pct, high_pct, low_th, high_th, hum;

  assign low_pct  = $signed({{(hhhc_pkg::ThW-hhhc_pkg::PctW){1'b0}}, setpoint_r})
                    - hhhc_pkg::ThW'(1);
  assign high_pct = $signed({{(hhhc_pkg::ThW-hhhc_pkg::PctW){1'b0}}, setpoint_r})
                    + hhhc_pkg::ThW'(1);
  assign low_th   = (low_pct <<< 3) + (low_pct <<< 1);
  assign high_th  = (high_pct <<< 3) + (high_pct <<< 1);
  assign hum      = $signed({{(hhhc_pkg::ThW-hhhc_pkg::HumW){1'b0}},
                             in_data.humidity_tenths});

  // Timers advance every tick, saturating at all ones, enabled or not.
  logic [hhhc_pkg::QTimerW-1:0] below_inc, above_inc;
  logic [hhhc_pkg::DwellW-1:0]  dwell_inc;

  assign below_inc = (&below_timer_r) ? below_timer_r : below_timer_r + 1'b1;
  assign above_inc = (&above_timer_r) ? above_timer_r : above_timer_r + 1'b1;
  assign dwell_inc = (&dwell_timer_r) ? dwell_timer_r : dwell_timer_r + 1'b1;

  // Below flag is evaluated whenever control is enabled; the above flag only
  // when the below flag stays clear, since a set below flag ends the decision.
  hhhc_pkg::qual_t below_q, above_q;
  logic            en;
  logic            above_en;

  assign en       = in_data.heater_enabled;
  assign above_en = en && !below_q.latched;

  hhhc_qual u_below_qual (
    .en        (en),
    .past      (hum < low_th),
    .back      (hum > low_th),
    .latched   (below_r),
    .timer_inc (below_inc),
    .qualify   (qualify_r),
    .qual      (below_q)
  );

  hhhc_qual u_above_qual (
    .en        (above_en),
    .past      (hum > high_th),
    .back      (hum < high_th),
    .latched   (above_r),
    .timer_inc (above_inc),
    .qualify   (qualify_r),
    .qual      (above_q)
  );

  // Heater decision with minimum dwell; the first change goes through at once.
  hhhc_pkg::act_t                 want_act;
  logic                           want;
  logic [hhhc_pkg::DwellCfgW-1:0] min_dwell;

  always_comb begin
    want      = 1'b0;
    want_act  = hhhc_pkg::ACT_OFF;
    min_dwell = min_on_r;
    if (en) begin
      if (below_q.latched) begin
        want = 1'b1;
      end else if (above_q.latched) begin
        want      = 1'b1;
        want_act  = hhhc_pkg::ACT_ON;
        min_dwell = min_off_r;
      end
    end
  end

  always_comb begin
    below_timer_nxt = below_q.restart ? '0 : below_inc;
    above_timer_nxt = above_q.restart ? '0 : above_inc;
    below_nxt       = below_q.latched;
    above_nxt       = above_q.latched;
    dwell_timer_nxt = dwell_inc;
    last_act_nxt    = last_act_r;
    first_nxt       = first_r;
    heater_nxt      = heater_r;
    if (want && (last_act_r != want_act) &&
        (first_r || (dwell_inc > {1'b0, min_dwell}))) begin
      first_nxt       = 1'b0;
      last_act_nxt    = want_act;
      dwell_timer_nxt = '0;
      heater_nxt      = (want_act == hhhc_pkg::ACT_ON);
    end
  end

  assign result.heater_drive = heater_nxt;
  assign result.below_flag   = below_nxt;
  assign result.above_flag   = above_nxt;

  // Configuration writes; codes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= hhhc_pkg::SetpointRst;
      qualify_r  <= hhhc_pkg::QualifyRst;
      min_on_r   <= hhhc_pkg::MinOnRst;
      min_off_r  <= hhhc_pkg::MinOffRst;
    end else if (cfg_valid && cfg_ready) begin
      case (hhhc_pkg::cfg_reg_t'(cfg_index))
        hhhc_pkg::CFG_SETPOINT: setpoint_r <= cfg_data[hhhc_pkg::PctW-1:0];
        hhhc_pkg::CFG_QUALIFY:  qualify_r  <= cfg_data[hhhc_pkg::QualW-1:0];
        hhhc_pkg::CFG_MIN_ON:   min_on_r   <= cfg_data[hhhc_pkg::DwellCfgW-1:0];
        hhhc_pkg::CFG_MIN_OFF:  min_off_r  <= cfg_data[hhhc_pkg::DwellCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the control state on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      below_timer_r <= '0;
      above_timer_r <= '0;
      dwell_timer_r <= '0;
      below_r       <= 1'b0;
      above_r       <= 1'b0;
      last_act_r    <= hhhc_pkg::ACT_NONE;
      first_r       <= 1'b1;
      heater_r      <= 1'b0;
    end else if (acc) begin
      below_timer_r <= below_timer_nxt;
      above_timer_r <= above_timer_nxt;
      dwell_timer_r <= dwell_timer_nxt;
      below_r       <= below_nxt;
      above_r       <= above_nxt;
      last_act_r    <= last_act_nxt;
      first_r       <= first_nxt;
      heater_r      <= heater_nxt;
    end
  end

  // Result buffer: refill the output register from the skid entry first, else
  // from the new beat; park the new beat in the skid entry while output holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      out_valid_r  <= skid_valid_r || acc;
      skid_valid_r <= 1'b0;
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (out_valid_r && !take && acc) begin
      skid_data_r <= result;
    end
  end

endmodule

### tb/sv/heater_ledger_pkg.sv
package heater_ledger_pkg;

  import hhhc_pkg::*;

  class heater_ledger;
    // register copies
    logic [PctW-1:0]      setpoint;
    logic [QualW-1:0]     qualify;
    logic [DwellCfgW-1:0] min_on;
    logic [DwellCfgW-1:0] min_off;

    // controller state, one tick per accepted beat
    logic [QTimerW-1:0]   below_timer;
    logic [QTimerW-1:0]   above_timer;
    logic                 below_latched;
    logic                 above_latched;
    logic [DwellW-1:0]    dwell_timer;
    act_t                 last_action;
    logic                 first_pending;
    logic                 heater_on;

    out_item_t drive_queue[$];
    int        errors;
    int        results;

    function new();
      setpoint      = SetpointRst;
      qualify       = QualifyRst;
      min_on        = MinOnRst;
      min_off       = MinOffRst;
      below_timer   = '0;
      above_timer   = '0;
      below_latched = 1'b0;
      above_latched = 1'b0;
      dwell_timer   = '0;
      last_action   = ACT_NONE;
      first_pending = 1'b1;
      heater_on     = 1'b0;
      errors        = 0;
      results       = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_SETPOINT: setpoint = val[PctW-1:0];
        CFG_QUALIFY:  qualify  = val[QualW-1:0];
        CFG_MIN_ON:   min_on   = val[DwellCfgW-1:0];
        CFG_MIN_OFF:  min_off  = val[DwellCfgW-1:0];
        default: ;
      endcase
    endfunction

    function void switch_heater(act_t act, logic [DwellCfgW-1:0] min_dwell);
      if (last_action == act) return;
      if (first_pending || dwell_timer > min_dwell) begin
        first_pending = 1'b0;
        last_action   = act;
        dwell_timer   = '0;
        heater_on     = (act == ACT_ON);
      end
    endfunction

    function void note_tick(in_item_t item);
      int        hum;
      int        low_th;
      int        high_th;
      out_item_t res;
      hum     = int'(item.humidity_tenths);
      low_th  = (int'(setpoint) - 1) * 10;
      high_th = (int'(setpoint) + 1) * 10;

      // elapsed time counts whether or not control is enabled
      below_timer = (&below_timer) ? below_timer : below_timer + 1'b1;
      above_timer = (&above_timer) ? above_timer : above_timer + 1'b1;
      dwell_timer = (&dwell_timer) ? dwell_timer : dwell_timer + 1'b1;

      if (item.heater_enabled) begin
        if (hum > low_th) begin
          below_latched = 1'b0;
          below_timer   = '0;
        end else if (hum < low_th && below_timer > qualify) begin
          below_latched = 1'b1;
        end

        // a set below flag ends the decision; the above side is left alone
        if (below_latched) begin
          switch_heater(ACT_OFF, min_on);
        end else begin
          if (hum < high_th) begin
            above_latched = 1'b0;
            above_timer   = '0;
          end else if (hum > high_th && above_timer > qualify) begin
            above_latched = 1'b1;
          end
          if (above_latched) switch_heater(ACT_ON, min_off);
        end
      end

      res.heater_drive = heater_on;
      res.below_flag   = below_latched;
      res.above_flag   = above_latched;
      drive_queue.push_back(res);
    endfunction

    task report(string msg);
      if (errors < 100) $display("ERROR: %s", msg);
      errors++;
    endtask

    task match_drive(out_item_t got);
      out_item_t want;
      results++;
      if (drive_queue.size() == 0) begin
        report($sformatf("result beat %0d arrived with no tick waiting", results));
      end else begin
        want = drive_queue.pop_front();
        if (got.heater_drive !== want.heater_drive)
          report($sformatf("beat %0d heater_drive got %b want %b", results,
                           got.heater_drive, want.heater_drive));
        if (got.below_flag !== want.below_flag)
          report($sformatf("beat %0d below_flag got %b want %b", results,
                           got.below_flag, want.below_flag));
        if (got.above_flag !== want.above_flag)
          report($sformatf("beat %0d above_flag got %b want %b", results,
                           got.above_flag, want.above_flag));
      end
    endtask
  endclass

endpackage

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hhhc_pkg::*;
  import heater_ledger_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int NumPhases  = 11;
  localparam int PhaseTicks = 120;
  localparam int NumDirected = 23;

  // Directed ticks, run at setpoint 50 (thresholds 490 / 510 tenths),
  // qualify 2, min on 3, min off 3:
  // - saturate high at full scale, so the above flag sets and the very
  //   first heater change fires at once
  // - sit exactly on the high threshold, then two disabled ticks that
  //   must freeze every decision
  // - drop to zero, touch the low threshold exactly, then hold low until
  //   the below flag sets and the heater may go off after its dwell
  // - jump high while the above timer kept running behind the below flag
  // - walk the band edges one tenth inside and outside
  localparam int DirHum[NumDirected] = '{1023, 1023, 1023, 1023, 510, 700, 0,
                                         0, 490, 0, 0, 0, 0, 0, 1000, 1000,
                                         1000, 500, 491, 509, 489, 511, 0};
  localparam bit DirEn[NumDirected]  = '{1, 1, 1, 1, 1, 0, 0,
                                         1, 1, 1, 1, 1, 1, 1, 1, 1,
                                         1, 1, 1, 1, 1, 1, 1};

  typedef enum int {SEG_BELOW, SEG_ABOVE, SEG_EDGE, SEG_BAND, SEG_NOISE} seg_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  heater_ledger ledger;
  int           gap_pct = 0;     // chance the sender idles after a beat
  int           stall_pct = 0;   // chance the receiver starts a stall burst
  int           stall_left = 0;
  int           ticks_sent = 0;
  int           cycles = 0;

  humidity_heater_hysteresis_control dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("humidity_heater_hysteresis_control: mismatch");
      $finish;
    end
  end

  // Result side: check every accepted beat, then pick the next stall value.
  // Outputs are read right after the edge, so they still hold the values
  // that the edge sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.match_drive(out_data);
    if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 9);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one tick, hold it until accepted, then maybe idle for a burst.
  task automatic send_tick(in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    ledger.note_tick(item);
    ticks_sent++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Hold the sender off until every pending result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.drive_queue.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers back to back; only called with the block idle.
  task automatic program_regs(int sp, int q, int on_ms, int off_ms);
    cfg_reg_t            idx;
    logic [CfgDataW-1:0] val;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_t'(i);
      case (idx)
        CFG_SETPOINT: val = CfgDataW'(sp);
        CFG_QUALIFY:  val = CfgDataW'(q);
        CFG_MIN_ON:   val = CfgDataW'(on_ms);
        default:      val = CfgDataW'(off_ms);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      ledger.write_reg(idx, val);
    end
    cfg_valid <= 1'b0;
  endtask

  // Humidity for one tick of a segment, placed relative to the thresholds.
  // Falls back to full-scale noise when the threshold lies out of reach.
  function automatic logic [HumW-1:0] pick_humidity(seg_t seg, int lo, int hi);
    int top;
    int bot;
    int v;
    v = $urandom_range(0, 1023);
    case (seg)
      SEG_BELOW: if (lo > 0) begin
        top = (lo - 1 > 1023) ? 1023 : lo - 1;
        bot = (top > 40) ? top - 40 : 0;
        v = $urandom_range(top, bot);
      end
      SEG_ABOVE: if (hi < 1023) begin
        bot = hi + 1;
        top = (hi + 40 > 1023) ? 1023 : hi + 40;
        v = $urandom_range(top, bot);
      end
      SEG_EDGE: begin
        top = $urandom_range(0, 1) ? lo : hi;
        if (top >= 0 && top <= 1023) v = top;
      end
      SEG_BAND: begin
        bot = (lo < 0) ? 0 : ((lo > 1023) ? 1023 : lo);
        top = (hi > 1023) ? 1023 : hi;
        v = $urandom_range(top, bot);
      end
      default: ;
    endcase
    return v[HumW-1:0];
  endfunction

  initial begin
    in_item_t item;
    seg_t     seg;
    int       sp;
    int       q;
    int       on_ms;
    int       off_ms;
    int       sent;
    int       seg_len;
    int       upto;
    int       pick;

    ledger = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few ticks on the reset defaults before any register is touched
    item = '{humidity_tenths: 10'd500, heater_enabled: 1'b1};
    send_tick(item);
    item = '{humidity_tenths: 10'd1023, heater_enabled: 1'b1};
    send_tick(item);
    item = '{humidity_tenths: 10'd0, heater_enabled: 1'b0};
    send_tick(item);
    drain();

    program_regs(50, 2, 3, 3);
    for (int i = 0; i < NumDirected; i++) begin
      item.humidity_tenths = HumW'(DirHum[i]);
      item.heater_enabled  = DirEn[i];
      send_tick(item);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: begin sp = 0;   q = 0;     on_ms = 0;       off_ms = 0;       end
        1: begin sp = 60;  q = 65535; on_ms = 1048575; off_ms = 1048575; end
        2: begin sp = 99;  q = 1;     on_ms = 0;       off_ms = 1048575; end
        3: begin sp = 1;   q = 0;     on_ms = 1048575; off_ms = 0;       end
        4: begin sp = 127; q = 3;     on_ms = 5;       off_ms = 5;       end
        default: begin
          sp     = $urandom_range(1, 99);
          q      = $urandom_range(0, 12);
          on_ms  = $urandom_range(0, 40);
          off_ms = $urandom_range(0, 40);
        end
      endcase
      // no gaps or stalls every third phase, nor in the last one
      if (ph == NumPhases - 1 || ph % 3 == 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(10, 40);
        stall_pct = $urandom_range(10, 40);
      end
      program_regs(sp, q, on_ms, off_ms);

      sent = 0;
      while (sent < PhaseTicks) begin
        pick = $urandom_range(0, 99);
        seg = (pick < 30) ? SEG_BELOW : (pick < 60) ? SEG_ABOVE :
              (pick < 72) ? SEG_EDGE : (pick < 87) ? SEG_BAND : SEG_NOISE;
        // runs long enough to qualify a flag and outlast the dwell when both are small
        upto = ((q > 20) ? 20 : q) +
               (((on_ms > off_ms ? on_ms : off_ms) > 40) ? 40 :
                (on_ms > off_ms ? on_ms : off_ms)) + 4;
        seg_len = $urandom_range(1, upto);
        for (int k = 0; k < seg_len && sent < PhaseTicks; k++) begin
          item.humidity_tenths = ($urandom_range(0, 9) == 0) ?
                                 HumW'($urandom_range(0, 1023)) :
                                 pick_humidity(seg, (sp - 1) * 10, (sp + 1) * 10);
          item.heater_enabled  = ($urandom_range(0, 11) != 0);
          send_tick(item);
          sent++;
          // hold the sender mid-phase until the block has caught up
          if (ph == 2 && sent == 60) drain();
        end
      end
    end

    drain();
    repeat (5) @(posedge clk);

    $display("ran %0d ticks across %0d register settings incl. setpoint 0 and 127,",
             ticks_sent, NumPhases + 2);
    $display("checked %0d result beats with random gaps and stalls", ledger.results);
    if (ledger.errors == 0 && ledger.drive_queue.size() == 0) begin
      $display("humidity_heater_hysteresis_control: match");
    end else begin
      $display("humidity_heater_hysteresis_control: mismatch");
    end
    $finish;
  end

endmodule
